// ----- hw/rtl/pct_pkg.sv -----
package pct_pkg;

  // Pipeline depth, one valid bit per register stage.
  localparam int NumStages = 10;

  // Field widths.
  localparam int CoefW   = 16;
  localparam int RawW    = 24;
  localparam int TempW   = 19;
  localparam int PresW   = 28;
  localparam int CfgIdxW = 3;

  // Output saturation bounds.
  localparam logic signed [TempW-1:0] TempLo = {1'b1, {(TempW-1){1'b0}}};
  localparam logic signed [TempW-1:0] TempHi = {1'b0, {(TempW-1){1'b1}}};
  localparam logic signed [PresW-1:0] PresLo = {1'b1, {(PresW-1){1'b0}}};
  localparam logic signed [PresW-1:0] PresHi = {1'b0, {(PresW-1){1'b1}}};

  // Calibration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_index_t;

  // Calibration words.
  typedef struct packed {
    logic [CoefW-1:0] c1;
    logic [CoefW-1:0] c2;
    logic [CoefW-1:0] c3;
    logic [CoefW-1:0] c4;
    logic [CoefW-1:0] c5;
    logic [CoefW-1:0] c6;
  } coeff_t;

  // First-order terms handed to the second-order correction.
  typedef struct packed {
    logic [RawW-1:0]     d1;
    logic signed [34:0]  sens;
    logic signed [35:0]  off;
    logic signed [18:0]  dev;   // TEMP - 2000
    logic signed [18:0]  e;     // TEMP + 1500
    logic [17:0]         ti;
    logic                low;
    logic                vlow;
  } fo_t;

  // Corrected terms handed to the pressure stages.
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [39:0]      s;     // SENS - SENSi
    logic signed [39:0]      o;     // OFF - OFFi
    logic signed [TempW-1:0] temp;  // clipped temperature
    logic                    tsat;
  } so_t;

  // Arithmetic shift right that rounds toward zero, like a signed divide by 2^sh.
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// ----- hw/rtl/pct_ctrl.sv -----
module pct_ctrl
  import pct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic [NumStages-1:0] stage_en
);

  logic [NumStages-1:0] valid;
  logic [NumStages-1:0] valid_next;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    stage_en[NumStages-1] = !valid[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid[k] || stage_en[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (stage_en[k]) begin
        valid_next[k] = (k == 0) ? in_valid : valid[(k == 0) ? 0 : k - 1];
      end else begin
        valid_next[k] = valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid[NumStages-1];

endmodule

// ----- hw/rtl/pct_first_order.sv -----
module pct_first_order
  import pct_pkg::*;
(
  input  logic            clk,
  input  logic [2:0]      stage_en,
  input  coeff_t          coef,
  input  logic [RawW-1:0] raw_pressure,
  input  logic [RawW-1:0] raw_temperature,
  output fo_t             fo
);

  // Stage 1: temperature difference dT.
  logic [RawW-1:0]    d1_a;
  logic signed [24:0] dt;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d1_a <= raw_pressure;
      dt   <= 25'($signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'b0}));
    end
  end

  // Stage 2: the four products of dT.
  logic [RawW-1:0]    d1_b;
  logic signed [41:0] m_sens;
  logic signed [41:0] m_off;
  logic signed [41:0] m_temp;
  logic signed [49:0] m_dtsq;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      d1_b   <= d1_a;
      m_sens <= $signed({1'b0, coef.c3}) * dt;
      m_off  <= $signed({1'b0, coef.c4}) * dt;
      m_temp <= $signed({1'b0, coef.c6}) * dt;
      m_dtsq <= dt * dt;
    end
  end

  // Stage 3: SENS, OFF, TEMP deviation, band flags and the temperature correction.
  logic signed [63:0] sens_q;
  logic signed [63:0] off_q;
  logic signed [63:0] dev_q;
  logic signed [18:0] dev_n;
  logic [47:0]        sq;
  logic [49:0]        sq3;
  logic               low_n;
  fo_t                fo_next;

  always_comb begin
    sens_q = trunc_shr(64'(m_sens), 8) + $signed(64'({coef.c1, 15'b0}));
    off_q  = trunc_shr(64'(m_off), 7) + $signed(64'({coef.c2, 16'b0}));
    dev_q  = trunc_shr(64'(m_temp), 23);
    dev_n  = 19'(dev_q);
    low_n  = dev_n < 19'sd0;
    // dT squared is never negative, so plain shifts divide it.
    sq     = m_dtsq[47:0];
    sq3    = {1'b0, sq, 1'b0} + {2'b0, sq};

    fo_next.d1   = d1_b;
    fo_next.sens = 35'(sens_q);
    fo_next.off  = 36'(off_q);
    fo_next.dev  = dev_n;
    fo_next.e    = 19'(dev_n + 19'sd3500);
    fo_next.low  = low_n;
    fo_next.vlow = dev_n < -19'sd3500;
    fo_next.ti   = low_n ? 18'(sq3[49:33]) : 18'(sq[47:36]);
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      fo <= fo_next;
    end
  end

endmodule

// ----- hw/rtl/pct_second_order.sv -----
module pct_second_order
  import pct_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] stage_en,
  input  fo_t        fo,
  output so_t        so
);

  // Stage 4: squares of the deviations and the corrected temperature.
  logic [RawW-1:0]    d1_a;
  logic signed [34:0] sens_a;
  logic signed [35:0] off_a;
  logic               low_a;
  logic               vlow_a;
  logic [34:0]        sqd;
  logic [35:0]        sqe;
  logic signed [20:0] temp_a;
  logic signed [37:0] sqd_p;
  logic signed [37:0] sqe_p;

  assign sqd_p = fo.dev * fo.dev;
  assign sqe_p = fo.e * fo.e;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d1_a   <= fo.d1;
      sens_a <= fo.sens;
      off_a  <= fo.off;
      low_a  <= fo.low;
      vlow_a <= fo.vlow;
      sqd    <= sqd_p[34:0];
      sqe    <= sqe_p[35:0];
      temp_a <= 21'(fo.dev) + 21'sd2000 - $signed({3'b0, fo.ti});
    end
  end

  // Stage 5: offset and sensitivity corrections per band; clip the temperature.
  logic [RawW-1:0]         d1_b;
  logic signed [34:0]      sens_b;
  logic signed [35:0]      off_b;
  logic [39:0]             offi;
  logic [39:0]             sensi;
  logic signed [TempW-1:0] temp_b;
  logic                    tsat_b;
  logic [39:0]             offi_next;
  logic [39:0]             sensi_next;
  logic [39:0]             sqd3;
  logic [39:0]             sqd5;
  logic [39:0]             sqe7;
  logic signed [TempW-1:0] temp_next;
  logic                    tsat_next;

  always_comb begin
    sqd3 = {4'b0, sqd, 1'b0} + {5'b0, sqd};
    sqd5 = {3'b0, sqd, 2'b0} + {5'b0, sqd};
    sqe7 = {1'b0, sqe, 3'b0} - {4'b0, sqe};
    if (low_a) begin
      offi_next  = {1'b0, sqd3[39:1]} + (vlow_a ? sqe7 : 40'd0);
      sensi_next = {3'b0, sqd5[39:3]} + (vlow_a ? {2'b0, sqe, 2'b0} : 40'd0);
    end else begin
      offi_next  = {9'b0, sqd[34:4]};
      sensi_next = 40'd0;
    end

    if (temp_a < 21'(TempLo)) begin
      temp_next = TempLo;
      tsat_next = 1'b1;
    end else if (temp_a > 21'(TempHi)) begin
      temp_next = TempHi;
      tsat_next = 1'b1;
    end else begin
      temp_next = TempW'(temp_a);
      tsat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      d1_b   <= d1_a;
      sens_b <= sens_a;
      off_b  <= off_a;
      offi   <= offi_next;
      sensi  <= sensi_next;
      temp_b <= temp_next;
      tsat_b <= tsat_next;
    end
  end

  // Stage 6: apply the corrections to SENS and OFF.
  so_t so_next;

  always_comb begin
    so_next.d1   = d1_b;
    so_next.s    = 40'(41'(sens_b) - $signed({1'b0, sensi}));
    so_next.o    = 40'(41'(off_b) - $signed({1'b0, offi}));
    so_next.temp = temp_b;
    so_next.tsat = tsat_b;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      so <= so_next;
    end
  end

endmodule

// ----- hw/rtl/pct_pressure.sv -----
module pct_pressure
  import pct_pkg::*;
(
  input  logic                    clk,
  input  logic [3:0]              stage_en,
  input  so_t                     so,
  output logic signed [TempW-1:0] temperature_centi,
  output logic signed [PresW-1:0] pressure_deci_mbar,
  output logic                    saturated
);

  // Stage 7: D1 times the corrected sensitivity, as two partial products.
  logic [43:0]             pl;
  logic signed [44:0]      ph;
  logic signed [39:0]      o_a;
  logic signed [TempW-1:0] temp_a;
  logic                    tsat_a;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pl     <= so.d1 * so.s[19:0];
      ph     <= $signed({1'b0, so.d1}) * $signed(so.s[39:20]);
      o_a    <= so.o;
      temp_a <= so.temp;
      tsat_a <= so.tsat;
    end
  end

  // Stage 8: join the partial products and divide by 2^21.
  logic signed [63:0]      prod;
  logic signed [43:0]      q;
  logic signed [39:0]      o_b;
  logic signed [TempW-1:0] temp_b;
  logic                    tsat_b;

  assign prod = (64'(ph) <<< 20) + $signed({20'b0, pl});

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q      <= 44'(trunc_shr(prod, 21));
      o_b    <= o_a;
      temp_b <= temp_a;
      tsat_b <= tsat_a;
    end
  end

  // Stage 9: subtract the corrected offset.
  logic signed [44:0]      r;
  logic signed [TempW-1:0] temp_c;
  logic                    tsat_c;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      r      <= 45'(q) - 45'(o_b);
      temp_c <= temp_b;
      tsat_c <= tsat_b;
    end
  end

  // Stage 10: divide by 2^13, clip the pressure and register the result.
  logic signed [63:0]      p64;
  logic signed [PresW-1:0] p_next;
  logic                    psat;

  always_comb begin
    p64 = trunc_shr(64'(r), 13);
    if (p64 < 64'(PresLo)) begin
      p_next = PresLo;
      psat   = 1'b1;
    end else if (p64 > 64'(PresHi)) begin
      p_next = PresHi;
      psat   = 1'b1;
    end else begin
      p_next = PresW'(p64);
      psat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      temperature_centi  <= temp_c;
      pressure_deci_mbar <= p_next;
      saturated          <= tsat_c | psat;
    end
  end

endmodule

// ----- hw/rtl/pressure_temp_compensation_top.sv -----
// Second-order barometric compensation. Each request carries one raw pressure
// and one raw temperature conversion; the result gives temperature in 0.01 degC
// and pressure in 0.1 mbar, both clipped to their output ranges with a flag
// when clipping occurred. The datapath is a ten-stage pipeline built around
// the multiplier stages: a new request is taken every cycle while the output
// side is not stalled. Empty stages fill while the output waits, so requests
// keep flowing until the pipeline is full. The user must write the six
// calibration words through the configuration port only while no request is in
// flight; the block does not enforce this. They reset to zero.
module pressure_temp_compensation_top
  import pct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RawW-1:0]         raw_pressure,
  input  logic [RawW-1:0]         raw_temperature,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [TempW-1:0] temperature_centi,
  output logic signed [PresW-1:0] pressure_deci_mbar,
  output logic                    saturated,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CoefW-1:0]        cfg_data
);

  coeff_t               coef;
  logic [NumStages-1:0] stage_en;
  fo_t                  fo;
  so_t                  so;

  // Calibration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_C1:  coef.c1 <= cfg_data;
        REG_C2:  coef.c2 <= cfg_data;
        REG_C3:  coef.c3 <= cfg_data;
        REG_C4:  coef.c4 <= cfg_data;
        REG_C5:  coef.c5 <= cfg_data;
        REG_C6:  coef.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  pct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .stage_en  (stage_en)
  );

  pct_first_order u_first (
    .clk             (clk),
    .stage_en        (stage_en[2:0]),
    .coef            (coef),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .fo              (fo)
  );

  pct_second_order u_second (
    .clk      (clk),
    .stage_en (stage_en[5:3]),
    .fo       (fo),
    .so       (so)
  );

  pct_pressure u_pres (
    .clk                (clk),
    .stage_en           (stage_en[9:6]),
    .so                 (so),
    .temperature_centi  (temperature_centi),
    .pressure_deci_mbar (pressure_deci_mbar),
    .saturated          (saturated)
  );

endmodule

// ----- hw/rtl/pct_checker.sv -----
module pct_assertions
  import pct_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [TempW-1:0] temperature_centi,
  input logic signed [PresW-1:0] pressure_deci_mbar,
  input logic                    saturated
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_centi)
      && $stable(pressure_deci_mbar) && $stable(saturated))
    else $error("stalled result changed");

  // When the output can drain, the whole pipeline moves and a request can be taken.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while the output side is free");

  // The clip flag only comes with a value sitting on a range bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> temperature_centi == TempLo
      || temperature_centi == TempHi || pressure_deci_mbar == PresLo
      || pressure_deci_mbar == PresHi)
    else $error("saturation flag without a clipped value");

endmodule

bind pressure_temp_compensation_top pct_assertions u_pct_checker (.*);

// ----- tb/pct_checker.sv -----
module pct_checker
  import pct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [RawW-1:0]         raw_pressure,
  input  logic [RawW-1:0]         raw_temperature,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [TempW-1:0] temperature_centi,
  input  logic signed [PresW-1:0] pressure_deci_mbar,
  input  logic                    saturated,
  input  logic                    cfg_we,
  input  logic [CfgIdxW-1:0]      cfg_index,
  input  logic [CoefW-1:0]        cfg_data,
  output int                      failures,
  output int                      outstanding
);

  // One compensated reading as the block should present it.
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pres;
    logic                    sat;
  } reading_t;

  // Shadow copy of the calibration words and the readings still owed.
  logic [CoefW-1:0] cal [6];
  reading_t         expected_readings [$];

  // Second-order compensation of one raw conversion pair, in 64-bit signed
  // arithmetic with divisions that truncate toward zero.
  function automatic reading_t compensate(input logic [RawW-1:0] d1_raw,
                                          input logic [RawW-1:0] d2_raw);
    longint   d1, d2, dt, temp, off, sens, ti, offi, sensi, dev, e, p;
    logic     sat;
    reading_t r;
    d1   = longint'(d1_raw);
    d2   = longint'(d2_raw);
    sat  = 1'b0;
    dt   = d2 - longint'(cal[REG_C5]) * 256;
    sens = longint'(cal[REG_C1]) * 32768 + (longint'(cal[REG_C3]) * dt) / 256;
    off  = longint'(cal[REG_C2]) * 65536 + (longint'(cal[REG_C4]) * dt) / 128;
    temp = 2000 + (dt * longint'(cal[REG_C6])) / 64'sd8388608;
    dev  = temp - 2000;

    if (temp < 2000) begin
      ti    = (3 * dt * dt) / 64'sd8589934592;
      offi  = (3 * dev * dev) / 2;
      sensi = (5 * dev * dev) / 8;
      // Very cold readings get a further correction on top of the low band.
      if (temp < -1500) begin
        e     = temp + 1500;
        offi  = offi + 7 * e * e;
        sensi = sensi + 4 * e * e;
      end
    end else begin
      ti    = (2 * dt * dt) / 64'sd137438953472;
      offi  = (dev * dev) / 16;
      sensi = 0;
    end

    temp = temp - ti;
    p    = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;

    // Clip both values to the output ranges and flag any clipping.
    if (temp < longint'(TempLo)) begin
      temp = longint'(TempLo);
      sat  = 1'b1;
    end else if (temp > longint'(TempHi)) begin
      temp = longint'(TempHi);
      sat  = 1'b1;
    end
    if (p < longint'(PresLo)) begin
      p   = longint'(PresLo);
      sat = 1'b1;
    end else if (p > longint'(PresHi)) begin
      p   = longint'(PresHi);
      sat = 1'b1;
    end

    r.temp = temp[TempW-1:0];
    r.pres = p[PresW-1:0];
    r.sat  = sat;
    return r;
  endfunction

  // Track writes, predict each accepted request and check each result.
  always @(posedge clk) begin : watch_channels
    reading_t want;
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        cal[i] = '0;
      end
      expected_readings.delete();
    end else begin
      // Writes to indexes past the last register are dropped by the block.
      if (cfg_we && cfg_index <= REG_C6) begin
        cal[cfg_index] = cfg_data;
      end

      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("result with no request pending: temperature_centi %0d, pressure_deci_mbar %0d",
                 temperature_centi, pressure_deci_mbar);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          if (temperature_centi !== want.temp) begin
            $error("temperature_centi mismatch: expected %0d, actual %0d",
                   want.temp, temperature_centi);
            failures++;
          end
          if (pressure_deci_mbar !== want.pres) begin
            $error("pressure_deci_mbar mismatch: expected %0d, actual %0d",
                   want.pres, pressure_deci_mbar);
            failures++;
          end
          if (saturated !== want.sat) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.sat, saturated);
            failures++;
          end
        end
      end

      if (in_valid && in_ready) begin
        expected_readings.push_back(compensate(raw_pressure, raw_temperature));
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import pct_pkg::*;

  localparam int WatchdogLimit  = 2000;
  localparam int HoldCycles     = 400;
  localparam int RandomPerPhase = 135;

  // Register indexes past the last calibration word.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam logic [RawW-1:0]  RawMax  = '1;
  localparam logic [CoefW-1:0] CoefMax = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [RawW-1:0]         raw_pressure = '0;
  logic [RawW-1:0]         raw_temperature = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [TempW-1:0] temperature_centi;
  logic signed [PresW-1:0] pressure_deci_mbar;
  logic                    saturated;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CoefW-1:0]        cfg_data = '0;

  int failures;
  int outstanding;
  int hold_asked = 0;
  int hold_served = 0;
  int send_calm_left = 0;
  int idle_cycles = 0;

  // Calibration as last written, used to aim requests at the band edges.
  logic [CoefW-1:0] cal_now [6] = '{default: '0};

  always #6 clk = ~clk;

  pressure_temp_compensation_top uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .pressure_deci_mbar(pressure_deci_mbar),
    .saturated         (saturated),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  pct_checker comp_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .pressure_deci_mbar(pressure_deci_mbar),
    .saturated         (saturated),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .failures          (failures),
    .outstanding       (outstanding)
  );

  // Random calibration word, with the extremes drawn often.
  function automatic logic [CoefW-1:0] pick_coeff();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CoefMax;
      default: return rnd[CoefW-1:0];
    endcase
  endfunction

  // Write all six words, then two writes past the end that must be ignored.
  task automatic write_calibration(input logic [CoefW-1:0] w0, input logic [CoefW-1:0] w1,
                                   input logic [CoefW-1:0] w2, input logic [CoefW-1:0] w3,
                                   input logic [CoefW-1:0] w4, input logic [CoefW-1:0] w5);
    logic [CoefW-1:0] words [6];
    words = '{w0, w1, w2, w3, w4, w5};
    cfg_we <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index  <= reg_index_t'(i);
      cfg_data   <= words[i];
      cal_now[i] = words[i];
      @(negedge clk);
    end
    cfg_index <= RegSpareLo;
    cfg_data  <= pick_coeff();
    @(negedge clk);
    cfg_index <= RegSpareHi;
    cfg_data  <= pick_coeff();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one request after a random gap and hold it until it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    int gap;
    if (send_calm_left > 0) begin
      gap = 0;
      send_calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      send_calm_left = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Extreme raw values on both inputs.
  task automatic send_corners();
    send_request('0, '0);
    send_request(RawMax, '0);
    send_request('0, RawMax);
    send_request(RawMax, RawMax);
  endtask

  // Random request: mostly full-range, some near the reference temperature,
  // some aimed at the low/high and very-low band thresholds.
  task automatic send_random_request();
    logic [31:0]     rnd;
    logic [RawW-1:0] d1;
    longint          d2, band_dt;
    rnd = $urandom;
    case ($urandom_range(0, 7))
      0:       d1 = '0;
      1:       d1 = RawMax;
      default: d1 = rnd[RawW-1:0];
    endcase
    rnd = $urandom;
    case ($urandom_range(0, 3))
      0, 1: d2 = longint'(rnd[RawW-1:0]);
      2: begin
        d2 = longint'(cal_now[REG_C5]) * 256 + longint'($urandom_range(0, 524288)) - 262144;
      end
      default: begin
        band_dt = ($urandom_range(0, 1) == 0) ? 64'sd0 : -64'sd3500;
        if (cal_now[REG_C6] != '0) begin
          band_dt = band_dt * 64'sd8388608 / longint'(cal_now[REG_C6]);
        end
        d2 = longint'(cal_now[REG_C5]) * 256 + band_dt + longint'($urandom_range(0, 8)) - 4;
      end
    endcase
    if (d2 < 0) begin
      d2 = 0;
    end else if (d2 > longint'(RawMax)) begin
      d2 = longint'(RawMax);
    end
    send_request(d1, d2[RawW-1:0]);
  endtask

  // Drop valid and wait until every result of the phase has come back.
  task automatic end_phase();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Result side: random stalls, calm stretches, and long hold-offs on demand.
  initial begin : receiver
    int stall;
    int calm_left;
    calm_left = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_served < hold_asked) begin
        stall = HoldCycles;
        hold_served++;
      end else if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = 0;
        calm_left = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Request side: directed phases, then random phases under several settings.
  initial begin : stimulus
    longint          dt_cold;
    logic [RawW-1:0] d2_ref;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Uncalibrated block: registers still hold their reset value.
    send_corners();
    end_phase();

    // Typical factory words; probe the reference point and the cold threshold.
    write_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
    send_corners();
    d2_ref  = {cal_now[REG_C5], 8'b0};
    dt_cold = -(64'sd3500 * 64'sd8388608) / longint'(cal_now[REG_C6]);
    send_request(24'd8500000, d2_ref);
    send_request(24'd8500000, d2_ref - 1'b1);
    for (int k = -1; k <= 1; k++) begin
      send_request(24'd8500000, d2_ref + dt_cold[RawW-1:0] + RawW'(k));
    end
    end_phase();

    // Every word at its maximum.
    write_calibration(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax, CoefMax);
    send_corners();
    end_phase();

    // No reference offset and the steepest temperature slope.
    write_calibration('0, '0, '0, CoefMax, '0, CoefMax);
    send_corners();
    end_phase();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
        2: write_calibration(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax, CoefMax);
        4: write_calibration(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(), '0,
                             CoefMax);
        6: write_calibration('0, '0, '0, '0, '0, '0);
        default: write_calibration(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                                   pick_coeff(), pick_coeff());
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        // Stall the result side long enough for the pipeline to fill up.
        if ((ph == 1 || ph == 5) && n == 60) begin
          hold_asked++;
        end
        send_random_request();
      end
      end_phase();
    end

    // Give any stray result time to show up before the verdict.
    repeat (2 * NumStages) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
